@@ rtl/mopl_pkg.sv @@
// shared types and constants for the madt override parser and lookup
package mopl_pkg;

  // input item kinds
  localparam logic ACT_BYTE   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // record layout
  localparam logic [7:0] ISO_TYPE    = 8'd2;
  localparam logic [7:0] ISO_MIN_LEN = 8'd10;
  localparam logic [7:0] HDR_LEN     = 8'd2;

  // record byte offsets
  localparam logic [7:0] OFF_TYPE = 8'd0;
  localparam logic [7:0] OFF_LEN  = 8'd1;
  localparam logic [7:0] OFF_BODY = 8'd2;
  localparam logic [7:0] OFF_SRC  = 8'd3;
  localparam logic [7:0] OFF_GSI0 = 8'd4;
  localparam logic [7:0] OFF_GSI1 = 8'd5;
  localparam logic [7:0] OFF_GSI2 = 8'd6;
  localparam logic [7:0] OFF_GSI3 = 8'd7;
  localparam logic [7:0] OFF_FLG0 = 8'd8;
  localparam logic [7:0] OFF_FLG1 = 8'd9;

  typedef struct packed {
    logic [7:0]  source;
    logic [31:0] gsi;
    logic [15:0] flags;
  } ovr_entry_t;

  typedef struct packed {
    logic       en;
    ovr_entry_t entry;
  } ovr_wr_t;

  typedef enum logic {
    LK_IDLE,
    LK_SCAN
  } lk_state_t;

endpackage

@@ rtl/mopl_ovr_mem.sv @@
// override entry store: one write port, one registered read port
module mopl_ovr_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  mopl_pkg::ovr_wr_t   wr,
  input  logic [AW-1:0]       wr_addr,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output mopl_pkg::ovr_entry_t rd_data
);
  import mopl_pkg::*;

  ovr_entry_t mem [DEPTH];
  ovr_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/mopl_parser.sv @@
// table byte parser: splits records and writes kept overrides to the store
module mopl_parser #(
  parameter int MAX_OVERRIDES = 16,
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_take,
  input  logic [7:0]        byte_data,
  input  logic              byte_last,
  output mopl_pkg::ovr_wr_t wr,
  output logic [AW-1:0]     wr_addr,
  output logic [CW-1:0]     ovr_count
);
  import mopl_pkg::*;

  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    off_r, off_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    src_r, src_nxt;
  logic [31:0]   gsi_r, gsi_nxt;
  logic [15:0]   flg_r, flg_nxt;
  logic          stop_r, stop_nxt;
  logic          in_tbl_r, in_tbl_nxt;

  logic [CW-1:0] count_eff;
  logic [7:0]    off_eff;
  logic          stop_eff;
  logic          keep;

  // a byte outside a table starts a fresh one
  assign count_eff = in_tbl_r ? count_r : '0;
  assign off_eff   = in_tbl_r ? off_r : OFF_TYPE;
  assign stop_eff  = in_tbl_r ? stop_r : 1'b0;
  assign keep      = (type_r == ISO_TYPE) && (len_r >= ISO_MIN_LEN) &&
                     (count_eff < CW'(MAX_OVERRIDES));

  always_comb begin
    count_nxt  = count_r;
    off_nxt    = off_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    src_nxt    = src_r;
    gsi_nxt    = gsi_r;
    flg_nxt    = flg_r;
    stop_nxt   = stop_r;
    in_tbl_nxt = in_tbl_r;
    wr         = '0;
    if (byte_take) begin
      in_tbl_nxt = 1'b1;
      count_nxt  = count_eff;
      off_nxt    = off_eff;
      stop_nxt   = stop_eff;
      if (!stop_eff) begin
        if (off_eff == OFF_TYPE) begin
          type_nxt = byte_data;
          src_nxt  = '0;
          gsi_nxt  = '0;
          flg_nxt  = '0;
          off_nxt  = OFF_LEN;
        end else if (off_eff == OFF_LEN) begin
          len_nxt = byte_data;
          if (byte_data < HDR_LEN) begin
            stop_nxt = 1'b1;
            off_nxt  = OFF_TYPE;
          end else if (byte_data == HDR_LEN) begin
            // header-only record is never long enough to keep
            off_nxt = OFF_TYPE;
          end else begin
            off_nxt = OFF_BODY;
          end
        end else begin
          if (off_eff == OFF_SRC)  src_nxt         = byte_data;
          if (off_eff == OFF_GSI0) gsi_nxt[7:0]   = byte_data;
          if (off_eff == OFF_GSI1) gsi_nxt[15:8]  = byte_data;
          if (off_eff == OFF_GSI2) gsi_nxt[23:16] = byte_data;
          if (off_eff == OFF_GSI3) gsi_nxt[31:24] = byte_data;
          if (off_eff == OFF_FLG0) flg_nxt[7:0]   = byte_data;
          if (off_eff == OFF_FLG1) flg_nxt[15:8]  = byte_data;
          if ((9'(off_eff) + 9'd1) >= 9'(len_r)) begin
            off_nxt = OFF_TYPE;
            if (keep) begin
              wr.en           = 1'b1;
              wr.entry.source = src_nxt;
              wr.entry.gsi    = gsi_nxt;
              wr.entry.flags  = flg_nxt;
              count_nxt       = count_eff + 1'b1;
            end
          end else begin
            off_nxt = off_eff + 8'd1;
          end
        end
      end
      if (byte_last) begin
        in_tbl_nxt = 1'b0;
        off_nxt    = OFF_TYPE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      off_r    <= '0;
      type_r   <= '0;
      len_r    <= '0;
      src_r    <= '0;
      gsi_r    <= '0;
      flg_r    <= '0;
      stop_r   <= 1'b0;
      in_tbl_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      off_r    <= off_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      src_r    <= src_nxt;
      gsi_r    <= gsi_nxt;
      flg_r    <= flg_nxt;
      stop_r   <= stop_nxt;
      in_tbl_r <= in_tbl_nxt;
    end
  end

  assign wr_addr   = count_eff[AW-1:0];
  assign ovr_count = count_r;

endmodule

@@ rtl/mopl_lookup.sv @@
// lookup sequencer: scans the store one entry per cycle for the first match
module mopl_lookup #(
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 query_take,
  input  logic [7:0]           query_irq,
  input  logic [CW-1:0]        ovr_count,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  mopl_pkg::ovr_entry_t rd_data,
  output logic                 busy,
  output logic                 res_valid,
  output logic                 res_found,
  output logic [31:0]          res_gsi,
  output logic [15:0]          res_flags
);
  import mopl_pkg::*;

  lk_state_t     state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [7:0]    irq_r, irq_nxt;
  logic          val_r, val_nxt;
  logic          fnd_r, fnd_nxt;
  logic [31:0]   gsi_r, gsi_nxt;
  logic [15:0]   flg_r, flg_nxt;
  logic          in_range, hit, at_end;

  assign in_range = CW'(idx_r) < ovr_count;
  assign hit      = in_range && (rd_data.source == irq_r);
  assign at_end   = (CW'(idx_r) + 1'b1) >= ovr_count;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    irq_nxt   = irq_r;
    val_nxt   = 1'b0;
    fnd_nxt   = fnd_r;
    gsi_nxt   = gsi_r;
    flg_nxt   = flg_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    unique case (state_r)
      LK_IDLE: begin
        if (query_take) begin
          irq_nxt   = query_irq;
          idx_nxt   = '0;
          rd_en     = 1'b1;
          rd_addr   = '0;
          state_nxt = LK_SCAN;
        end
      end
      LK_SCAN: begin
        if (hit) begin
          val_nxt   = 1'b1;
          fnd_nxt   = 1'b1;
          gsi_nxt   = rd_data.gsi;
          flg_nxt   = rd_data.flags;
          state_nxt = LK_IDLE;
        end else if (at_end) begin
          val_nxt   = 1'b1;
          fnd_nxt   = 1'b0;
          gsi_nxt   = 32'(irq_r);
          flg_nxt   = '0;
          state_nxt = LK_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end
      default: state_nxt = LK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LK_IDLE;
      val_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      val_r   <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    irq_r <= irq_nxt;
    fnd_r <= fnd_nxt;
    gsi_r <= gsi_nxt;
    flg_r <= flg_nxt;
  end

  assign busy      = (state_r != LK_IDLE);
  assign res_valid = val_r;
  assign res_found = fnd_r;
  assign res_gsi   = gsi_r;
  assign res_flags = flg_r;

endmodule

@@ rtl/madt_override_parser_lookup.sv @@
// top level of the madt interrupt source override parser and lookup
//
// command channel: a transfer happens at a rising edge with start high and
// busy low. in_action selects the kind of item:
//   table byte (in_action 0): in_table_byte is one byte of the madt entry
//     region, in_table_end marks the last one. busy stays low for bytes,
//     so bytes may arrive back to back. no result.
//   lookup (in_action 1): in_query_irq is searched among the overrides kept
//     so far. exactly one result follows.
// result channel: out_valid is high for exactly one cycle with out_found,
// out_gsi and out_polarity_trigger_flags. there is no backpressure; the
// receiver must take the transfer in that cycle.
// scan: a lookup returns once the first matching entry (by position) is
// read, or once the last entry held is checked when nothing matches. the
// scan reads the override store one entry per cycle through its single
// registered read port; busy covers the scan.
// reset: synchronous on rst_n low; the override count and record parser
// state are cleared, store contents are not (entries past the count are
// never used).
module madt_override_parser_lookup #(
  parameter int MAX_OVERRIDES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_table_byte,
  input  logic        in_table_end,
  input  logic [7:0]  in_query_irq,
  output logic        out_valid,
  output logic        out_found,
  output logic [31:0] out_gsi,
  output logic [15:0] out_polarity_trigger_flags
);
  import mopl_pkg::*;

  localparam int AW = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;
  localparam int CW = $clog2(MAX_OVERRIDES + 1);

  logic          byte_take, query_take;
  ovr_wr_t       wr;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] ovr_count;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  ovr_entry_t    rd_data;

  // bytes are only taken while no scan runs, so the store never sees a
  // write and a scan read of the same entry in flight together
  assign byte_take  = start && !busy && (in_action == ACT_BYTE);
  assign query_take = start && !busy && (in_action == ACT_LOOKUP);

  mopl_parser #(
    .MAX_OVERRIDES(MAX_OVERRIDES),
    .AW(AW),
    .CW(CW)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .byte_data (in_table_byte),
    .byte_last (in_table_end),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .ovr_count (ovr_count)
  );

  mopl_ovr_mem #(
    .DEPTH(MAX_OVERRIDES),
    .AW(AW)
  ) u_mem (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mopl_lookup #(
    .AW(AW),
    .CW(CW)
  ) u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .query_take (query_take),
    .query_irq  (in_query_irq),
    .ovr_count  (ovr_count),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .busy       (busy),
    .res_valid  (out_valid),
    .res_found  (out_found),
    .res_gsi    (out_gsi),
    .res_flags  (out_polarity_trigger_flags)
  );

`ifndef SYNTH
  // no store write while a scan is running
  a_no_wr_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !busy)
    else $error("override store written during a scan");

  // a lookup transfer always starts a scan
  a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
    query_take |=> busy)
    else $error("lookup transfer did not start a scan");

  // a result only follows the end of a scan
  a_res_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside the end of a scan");

  // a miss echoes the irq with zero flags
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_polarity_trigger_flags == 16'd0) &&
    (out_gsi[31:8] == 24'd0))
    else $error("miss result carries nonzero flags or gsi upper bits");
`endif

endmodule
